FILE: hw/rtl/led_matrix_chain_frame_buffer_defines.svh
// assertion macros for the checker file of the frame buffer
`ifndef LED_MATRIX_CHAIN_FRAME_BUFFER_DEFINES_SVH
`define LED_MATRIX_CHAIN_FRAME_BUFFER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LMCFB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define LMCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lmcfb_pkg.sv
// shared constants and types of the led matrix chain frame buffer
package lmcfb_pkg;

	localparam int MAX_CHIPS = 8;
	localparam int BUF_DEPTH = MAX_CHIPS * 8;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	localparam int TYPE_W = 2;
	localparam int POS_W  = 6;
	localparam int REG_W  = 4;
	localparam int BYTE_W = 8;
	localparam int CHIP_W = 3;
	localparam int CNT_W  = 4;
	localparam int CFG_AW = 5;
	localparam int APB_DW = 32;

	typedef logic [BUF_AW-1:0] buf_addr_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// request types
	localparam logic [TYPE_W-1:0] REQ_PIXEL   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FILL    = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_REFRESH = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_CTRL    = 2'd3;

	// chain directions
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_CHIP_COUNT   = 3'd0;
	localparam logic [2:0] CFG_CHAIN_DIR    = 3'd1;
	localparam logic [2:0] CFG_SWAP_RC      = 3'd2;
	localparam logic [2:0] CFG_REVERSE_ROWS = 3'd3;
	localparam logic [2:0] CFG_REVERSE_COLS = 3'd4;

endpackage

FILE: hw/rtl/lmcfb_req_if.sv
// request channel: valid/ready handshake with the request fields
interface lmcfb_req_if;
	import lmcfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic              pixel_on;
	logic [REG_W-1:0]  ctrl_register;
	logic [BYTE_W-1:0] ctrl_value;

	modport source (
		output valid, req_type, pos_x, pos_y, pixel_on, ctrl_register, ctrl_value,
		input  ready
	);

	modport sink (
		input  valid, req_type, pos_x, pos_y, pixel_on, ctrl_register, ctrl_value,
		output ready
	);

endinterface

FILE: hw/rtl/lmcfb_word_if.sv
// serial word channel: valid/ready handshake with one chip word
interface lmcfb_word_if;
	import lmcfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [REG_W-1:0]  reg_addr;
	logic [BYTE_W-1:0] data_byte;
	logic [CHIP_W-1:0] chip_index;
	logic              frame_end;
	logic              last;

	modport source (
		output valid, reg_addr, data_byte, chip_index, frame_end, last,
		input  ready
	);

	modport sink (
		input  valid, reg_addr, data_byte, chip_index, frame_end, last,
		output ready
	);

endinterface

FILE: hw/rtl/led_matrix_chain_frame_buffer.sv
// frame buffer and scan-out for a chain of 8x8 led matrix driver chips
//
//  channel | direction | moves
//  req     | in        | pixel, fill, refresh or control request
//  words   | out       | one register/data word for one chip
//  apb     | in        | configuration register writes and reads
//
// a pixel reads the buffer at acceptance and writes the modified byte next
// fill writes 8*chips buffer bytes, one buffer byte per cycle
// refresh sends 8*chips words and control chips words, one buffer read per cycle
// while words is not stalled, feeding a single output register
// a stall on words holds the buffer read and the output register in place
// reset clears the buffer through per-byte valid bits, no clearing pass
module led_matrix_chain_frame_buffer (
	input  logic                          clk,
	input  logic                          arst_n,
	lmcfb_req_if.sink                     req,
	lmcfb_word_if.source                  words,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmcfb_pkg::CFG_AW-1:0]  paddr,
	input  logic [lmcfb_pkg::APB_DW-1:0]  pwdata,
	output logic [lmcfb_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import lmcfb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PIX  = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	// configuration registers
	logic [CNT_W-1:0] chip_count_q;
	logic [1:0]       chain_dir_q;
	logic             swap_q;
	logic             rev_rows_q;
	logic             rev_cols_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[CFG_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_count_q <= CNT_W'(1);
			chain_dir_q  <= DIR_UP;
			swap_q       <= 1'b0;
			rev_rows_q   <= 1'b0;
			rev_cols_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				CFG_CHIP_COUNT:   chip_count_q <= pwdata[CNT_W-1:0];
				CFG_CHAIN_DIR:    chain_dir_q  <= pwdata[1:0];
				CFG_SWAP_RC:      swap_q       <= pwdata[0];
				CFG_REVERSE_ROWS: rev_rows_q   <= pwdata[0];
				CFG_REVERSE_COLS: rev_cols_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			CFG_CHIP_COUNT:   prdata = APB_DW'(chip_count_q);
			CFG_CHAIN_DIR:    prdata = APB_DW'(chain_dir_q);
			CFG_SWAP_RC:      prdata = APB_DW'(swap_q);
			CFG_REVERSE_ROWS: prdata = APB_DW'(rev_rows_q);
			CFG_REVERSE_COLS: prdata = APB_DW'(rev_cols_q);
			default:          prdata = '0;
		endcase
	end

	// chips in use, clamped to 1..MAX_CHIPS
	logic [CNT_W-1:0]  chips_n;
	logic [CHIP_W-1:0] chip_last;
	logic [BUF_AW:0]   buf_len;
	buf_addr_t         buf_last;

	always_comb begin
		if (chip_count_q == '0) begin
			chips_n = CNT_W'(1);
		end else if (chip_count_q > CNT_W'(MAX_CHIPS)) begin
			chips_n = CNT_W'(MAX_CHIPS);
		end else begin
			chips_n = chip_count_q;
		end
	end

	assign chip_last = CHIP_W'(chips_n - CNT_W'(1));
	assign buf_len   = {chips_n, 3'b000};
	assign buf_last  = BUF_AW'(buf_len - (BUF_AW+1)'(1));

	// pixel coordinate mapping, signed so that mirrored values may go negative
	logic signed [7:0] px8, py8, wmax;
	logic signed [7:0] mx0, my0, mx1, my1, mx2, my2;
	logic [6:0]        pix_off;
	logic              pix_keep;
	buf_addr_t         pix_addr;

	assign px8  = {2'b00, req.pos_x};
	assign py8  = {2'b00, req.pos_y};
	assign wmax = $signed({1'b0, chips_n, 3'b000}) - 8'sd1;

	always_comb begin
		case (chain_dir_q)
			DIR_UP: begin
				mx0 = py8;
				my0 = px8;
			end
			DIR_DOWN: begin
				mx0 = wmax - py8;
				my0 = 8'sd7 - px8;
			end
			DIR_LEFT: begin
				mx0 = px8;
				my0 = 8'sd7 - py8;
			end
			default: begin
				mx0 = wmax - px8;
				my0 = py8;
			end
		endcase

		if (swap_q) begin
			mx1 = {mx0[7:3], my0[2:0]};
			my1 = {5'b00000, ~mx0[2:0]};
		end else begin
			mx1 = mx0;
			my1 = my0;
		end

		my2 = rev_cols_q ? 8'sd7 - my1 : my1;
		mx2 = rev_rows_q ? {mx1[7:3], ~mx1[2:0]} : mx1;

		pix_off  = {4'b0000, my2[2:0]} * {3'b000, chips_n} + {3'b000, mx2[6:3]};
		pix_keep = !mx2[7] && !my2[7] && (my2[6:3] == 4'd0)
			&& (pix_off < buf_len);
		pix_addr = pix_off[BUF_AW-1:0];
	end

	// control state
	logic [1:0]        state_q;
	logic [BUF_DEPTH-1:0] valid_q;
	buf_addr_t         idx_q;
	logic [CHIP_W-1:0] chip_q;
	logic [2:0]        row_q;
	logic              issue_done_q;
	logic              mode_ctrl_q;
	logic [REG_W-1:0]  creg_q;
	byte_t             cval_q;
	byte_t             fill_byte_q;

	// pixel read-modify-write stage
	logic              pix_keep_s1;
	buf_addr_t         pix_addr_s1;
	logic [2:0]        pix_bit_s1;
	logic              pix_on_s1;
	logic              pix_vld_s1;

	// scan read stage
	logic              rd_vld_s1;
	logic              bvld_s1;
	logic [REG_W-1:0]  reg_s1;
	logic [CHIP_W-1:0] chip_s1;
	logic              fend_s1;
	logic              last_s1;

	// output register
	logic              out_vld_q;
	logic [REG_W-1:0]  out_reg_q;
	byte_t             out_data_q;
	logic [CHIP_W-1:0] out_chip_q;
	logic              out_fend_q;
	logic              out_last_q;

	logic      req_acc;
	logic      can_load;
	logic      load;
	logic      issue;
	logic      word_fend;
	logic      word_last;
	logic      ram_we, ram_re;
	buf_addr_t ram_waddr, ram_raddr;
	byte_t     ram_wdata, ram_rdata;
	byte_t     pix_base, pix_mask;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid & req.ready;
	assign can_load  = !out_vld_q || words.ready;
	assign load      = rd_vld_s1 && can_load;
	assign issue     = (state_q == ST_SCAN) && !issue_done_q && (!rd_vld_s1 || can_load);
	assign word_fend = (chip_q == chip_last);
	assign word_last = word_fend && (mode_ctrl_q || row_q == 3'd7);

	assign pix_base = pix_vld_s1 ? ram_rdata : '0;
	assign pix_mask = BYTE_W'(1) << pix_bit_s1;

	assign ram_re    = req_acc || issue;
	assign ram_raddr = (state_q == ST_IDLE) ? pix_addr : idx_q;
	assign ram_we    = ((state_q == ST_PIX) && pix_keep_s1) || (state_q == ST_FILL);
	assign ram_waddr = (state_q == ST_FILL) ? idx_q : pix_addr_s1;
	assign ram_wdata = (state_q == ST_FILL) ? fill_byte_q
		: (pix_on_s1 ? (pix_base | pix_mask) : (pix_base & ~pix_mask));

	lmcfb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			chip_q       <= '0;
			row_q        <= '0;
			issue_done_q <= 1'b0;
			mode_ctrl_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						idx_q        <= '0;
						chip_q       <= '0;
						row_q        <= '0;
						issue_done_q <= 1'b0;
						mode_ctrl_q  <= (req.req_type == REQ_CTRL);
						case (req.req_type)
							REQ_PIXEL: state_q <= ST_PIX;
							REQ_FILL:  state_q <= ST_FILL;
							default:   state_q <= ST_SCAN;
						endcase
					end
				end
				ST_PIX: begin
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					idx_q <= idx_q + BUF_AW'(1);
					if (idx_q == buf_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + BUF_AW'(1);
						if (word_fend) begin
							chip_q <= '0;
							row_q  <= row_q + 3'd1;
						end else begin
							chip_q <= chip_q + CHIP_W'(1);
						end
						if (word_last) begin
							issue_done_q <= 1'b1;
						end
					end
					// leave once the last read has moved into the output register
					if (issue_done_q && (!rd_vld_s1 || can_load)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (load) begin
				rd_vld_s1 <= 1'b0;
			end

			if (load) begin
				out_vld_q <= 1'b1;
			end else if (words.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			pix_keep_s1 <= pix_keep;
			pix_addr_s1 <= pix_addr;
			pix_bit_s1  <= mx2[2:0];
			pix_on_s1   <= req.pixel_on;
			pix_vld_s1  <= valid_q[pix_addr];
			creg_q      <= req.ctrl_register;
			cval_q      <= req.ctrl_value;
			fill_byte_q <= req.pixel_on ? '1 : '0;
		end
		if (issue) begin
			bvld_s1 <= valid_q[idx_q];
			reg_s1  <= mode_ctrl_q ? creg_q : REG_W'(row_q) + REG_W'(1);
			chip_s1 <= chip_q;
			fend_s1 <= word_fend;
			last_s1 <= word_last;
		end
		if (load) begin
			out_reg_q  <= reg_s1;
			out_data_q <= mode_ctrl_q ? cval_q : (bvld_s1 ? ram_rdata : '0);
			out_chip_q <= chip_s1;
			out_fend_q <= fend_s1;
			out_last_q <= last_s1;
		end
	end

	assign words.valid      = out_vld_q;
	assign words.reg_addr   = out_reg_q;
	assign words.data_byte  = out_data_q;
	assign words.chip_index = out_chip_q;
	assign words.frame_end  = out_fend_q;
	assign words.last       = out_last_q;

endmodule

FILE: hw/rtl/lmcfb_ram.sv
// generic simple dual-port ram with registered read
module lmcfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lmcfb_checker.sv
// port-level checker for the frame buffer, bound to the top level
`include "led_matrix_chain_frame_buffer_defines.svh"

module lmcfb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         words_valid,
	input logic                         words_ready,
	input logic [lmcfb_pkg::REG_W-1:0]  reg_addr,
	input logic [lmcfb_pkg::BYTE_W-1:0] data_byte,
	input logic [lmcfb_pkg::CHIP_W-1:0] chip_index,
	input logic                         frame_end,
	input logic                         last
);
	import lmcfb_pkg::*;

	// a stalled word keeps its payload
	`LMCFB_ASSERT_NEXT(a_word_hold, clk, arst_n, words_valid && !words_ready, words_valid && $stable(reg_addr) && $stable(data_byte) && $stable(chip_index) && $stable(frame_end) && $stable(last), "word changed while stalled")

	// the final word of a request always closes a chip group
	`LMCFB_ASSERT_SAME(a_last_fend, clk, arst_n, words_valid && last, frame_end, "last word without frame end")

	// the highest chip position is always the end of its group
	`LMCFB_ASSERT_SAME(a_top_chip_fend, clk, arst_n, words_valid && (chip_index == CHIP_W'(MAX_CHIPS - 1)), frame_end, "top chip without frame end")

	// every transaction on req keeps the block busy for at least the next cycle
	`LMCFB_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "request taken on consecutive cycles")

endmodule

bind led_matrix_chain_frame_buffer lmcfb_checker u_lmcfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.words_valid (words.valid),
	.words_ready (words.ready),
	.reg_addr    (words.reg_addr),
	.data_byte   (words.data_byte),
	.chip_index  (words.chip_index),
	.frame_end   (words.frame_end),
	.last        (words.last)
);
